/* rtl/core/lidar_zone_stop_gear_monitor_macros.svh */
// Assertion macros for the lidar zone stop / gear monitor checker.
// Expects signals named clk and arst_n in the including scope.
`ifndef LIDAR_ZONE_STOP_GEAR_MONITOR_MACROS_SVH
`define LIDAR_ZONE_STOP_GEAR_MONITOR_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define LZSGM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lzsgm: same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define LZSGM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lzsgm: next-cycle check failed");

`endif

/* rtl/core/lzsgm_pkg.sv */
// Shared types and constants for the lidar zone stop / gear monitor.
// No dependencies.
package lzsgm_pkg;

	localparam int SCAN_POINTS = 1024;
	localparam int IDX_W       = 10;
	localparam int IDX_CMP_W   = $clog2(SCAN_POINTS) + 1;
	localparam logic [IDX_CMP_W-1:0] HALF_IDX = IDX_CMP_W'(SCAN_POINTS / 2);

	localparam int CFG_DATA_W  = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int COUNT_W     = 11;

	localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
	localparam logic [COUNT_W-1:0] FREE_STOP_LIMIT = 11'd9;
	localparam logic [16:0]        CLEAR_MARGIN_MM = 17'd100;
	localparam logic signed [15:0] SLOW_SPEED_MM_S = 16'sd100;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_START   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_END     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_LEN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AREA1_LEN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_THR   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_THR   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UP_GEAR_TCK = 3'd7;

	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_SPEED  = 2'd1,
		ACT_TICK   = 2'd2
	} action_t;

	localparam logic [1:0] GEAR_FREE = 2'd0;
	localparam logic [1:0] GEAR_SLOW = 2'd1;
	localparam logic [1:0] GEAR_STOP = 2'd2;

	localparam logic MOTION_STOP   = 1'b0;
	localparam logic MOTION_RECOIL = 1'b1;

	typedef enum logic [4:0] {
		MM_NONE   = 5'b00001,
		MM_STOP   = 5'b00010,
		MM_GEAR1  = 5'b00100,
		MM_FREE   = 5'b01000,
		MM_RECOIL = 5'b10000
	} motion_mode_t;

	// Result word, lowest bit last in the list
	typedef struct packed {
		logic       light_alert;
		logic       light_valid;
		logic       motion_kind;
		logic       motion_valid;
		logic [1:0] gear_level;
		logic       gear_valid;
	} result_t;

	localparam int RES_W   = $bits(result_t);
	localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
	localparam int S_TDATA_W = 64;

endpackage

/* rtl/core/lidar_zone_stop_gear_monitor.sv */
// Lidar zone stop / gear monitor: top level, input stage, decision logic, result register.
// Depends on lzsgm_pkg.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-----------------------------------------------
//  s_*     | in  | s_tvalid/tready  | tuser=action, tlast=last_in_scan, tdata=sample
//  m_*     | out | m_tvalid/tready  | tdata=gear/motion/light flags, one per request
//  cfg_*   | in  | cfg_we only      | cfg_index selects register, cfg_data value
//
// Every request gives exactly one result, through the input register and then the result register.
// Throughput is one request per cycle while m_tready is high; the state update and result sit in one stage.
// arst_n clears control state and loads the configuration reset values.
// A stall on m_tready holds the result register; the input register still takes one
// more request, then s_tready drops until the result moves.
module lidar_zone_stop_gear_monitor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// tdata: sample_index[9:0], range_mm[25:10], intensity[41:26],
	//        speed_mm_s[57:42], zero[63:58]
	input  logic [lzsgm_pkg::S_TDATA_W-1:0]      s_tdata,
	input  logic                                 s_tlast,   // last_in_scan
	input  logic [1:0]                           s_tuser,   // action
	// master stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// tdata: gear_valid[0], gear_level[2:1], motion_valid[3], motion_kind[4],
	//        light_valid[5], light_alert[6], zero[7]
	output logic [lzsgm_pkg::M_TDATA_W-1:0]      m_tdata,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [lzsgm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lzsgm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// ---------------- configuration registers ----------------
	logic [1:0]  mode_flags_q;
	logic [9:0]  win_start_q;
	logic [9:0]  win_end_q;
	logic [15:0] stop_len_q;
	logic [15:0] area1_len_q;
	logic [21:0] count_thr_q;
	logic [47:0] speed_thr_q;
	logic [31:0] up_gear_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_flags_q    <= 2'd0;
			win_start_q     <= 10'd0;
			win_end_q       <= 10'd1023;
			stop_len_q      <= 16'd500;
			area1_len_q     <= 16'd1500;
			count_thr_q     <= 22'd0;
			speed_thr_q     <= 48'd0;
			up_gear_ticks_q <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				lzsgm_pkg::REG_MODE_FLAGS:  mode_flags_q    <= cfg_data[1:0];
				lzsgm_pkg::REG_WIN_START:   win_start_q     <= cfg_data[9:0];
				lzsgm_pkg::REG_WIN_END:     win_end_q       <= cfg_data[9:0];
				lzsgm_pkg::REG_STOP_LEN:    stop_len_q      <= cfg_data[15:0];
				lzsgm_pkg::REG_AREA1_LEN:   area1_len_q     <= cfg_data[15:0];
				lzsgm_pkg::REG_COUNT_THR:   count_thr_q     <= cfg_data[21:0];
				lzsgm_pkg::REG_SPEED_THR:   speed_thr_q     <= cfg_data[47:0];
				lzsgm_pkg::REG_UP_GEAR_TCK: up_gear_ticks_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	logic                                valid_s1;
	lzsgm_pkg::action_t                  act_s1;
	logic [lzsgm_pkg::IDX_W-1:0]         idx_s1;
	logic [15:0]                         range_s1;
	logic [15:0]                         inten_s1;
	logic                                last_s1;
	logic signed [15:0]                  speed_s1;

	logic m_valid_q;
	logic advance;

	// Stage moves when the result register is free or is being drained this cycle
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_s1   <= lzsgm_pkg::action_t'(s_tuser);
			idx_s1   <= s_tdata[9:0];
			range_s1 <= s_tdata[25:10];
			inten_s1 <= s_tdata[41:26];
			speed_s1 <= s_tdata[57:42];
			last_s1  <= s_tlast;
		end
	end

	// ---------------- monitor state ----------------
	logic [lzsgm_pkg::COUNT_W-1:0] stop_cnt_q, right_cnt_q, left_cnt_q;
	logic                          decided_q;
	logic [1:0]                    down_conf_q, up_conf_q;
	lzsgm_pkg::motion_mode_t       mode_q;
	logic                          stopping_q;
	logic signed [15:0]            cur_speed_q;
	logic [31:0]                   since_slow_q;

	logic [lzsgm_pkg::COUNT_W-1:0] stop_cnt_d, right_cnt_d, left_cnt_d;
	logic                          decided_d;
	logic [1:0]                    down_conf_d, up_conf_d;
	lzsgm_pkg::motion_mode_t       mode_d;
	logic                          stopping_d;
	logic signed [15:0]            cur_speed_d;
	logic [31:0]                   since_slow_d;
	lzsgm_pkg::result_t            res_d, res_q;

	// signed speed against an unsigned 16-bit threshold
	function automatic logic speed_ge(input logic signed [15:0] spd, input logic [15:0] thr);
		return $signed({spd[15], spd}) >= $signed({1'b0, thr});
	endfunction

	function automatic logic [lzsgm_pkg::COUNT_W-1:0] sat_inc(
		input logic [lzsgm_pkg::COUNT_W-1:0] c);
		return (c != lzsgm_pkg::COUNT_MAX) ? c + 1'b1 : c;
	endfunction

	logic                            enabled;
	logic [lzsgm_pkg::COUNT_W-1:0]   stop_thr, grp_thr;
	logic [lzsgm_pkg::IDX_CMP_W-1:0] idx_ext;
	logic [16:0]                     band_low;
	logic                            band, in_window, right_zone, left_zone, near_end;
	logic                            right_ok, left_ok, both_ok;
	logic [10:0]                     idx_plus2;

	assign enabled  = mode_flags_q[0];
	assign stop_thr = count_thr_q[10:0];
	assign grp_thr  = count_thr_q[21:11];
	assign idx_ext  = lzsgm_pkg::IDX_CMP_W'(idx_s1);
	assign band_low = {1'b0, stop_len_q} + lzsgm_pkg::CLEAR_MARGIN_MM;
	assign band     = ({1'b0, range_s1} >= band_low) && (range_s1 <= area1_len_q);
	assign in_window = (idx_s1 >= win_start_q) && (idx_s1 < win_end_q)
		&& (range_s1 != 16'd0) && (inten_s1 != 16'd0);
	assign right_zone = (idx_s1 >= win_start_q) && (idx_ext <= lzsgm_pkg::HALF_IDX) && band;
	assign left_zone  = (idx_ext >= lzsgm_pkg::HALF_IDX) && (idx_s1 <= win_end_q) && band;
	assign idx_plus2  = {1'b0, idx_s1} + 11'd2;
	assign near_end   = idx_plus2 >= {1'b0, win_end_q};

	always_comb begin
		stop_cnt_d   = stop_cnt_q;
		right_cnt_d  = right_cnt_q;
		left_cnt_d   = left_cnt_q;
		decided_d    = decided_q;
		down_conf_d  = down_conf_q;
		up_conf_d    = up_conf_q;
		mode_d       = mode_q;
		stopping_d   = stopping_q;
		cur_speed_d  = cur_speed_q;
		since_slow_d = since_slow_q;
		res_d        = '0;
		right_ok     = 1'b0;
		left_ok      = 1'b0;
		both_ok      = 1'b0;

		case (act_s1)
			lzsgm_pkg::ACT_SAMPLE: begin
				if (enabled) begin
					if (!decided_q && in_window) begin
						// zone counting, stop zone has priority
						if (range_s1 <= stop_len_q) begin
							stop_cnt_d = sat_inc(stop_cnt_q);
						end else if (right_zone) begin
							right_cnt_d = sat_inc(right_cnt_q);
						end else if (left_zone) begin
							left_cnt_d = sat_inc(left_cnt_q);
						end
						right_ok = right_cnt_d >= grp_thr;
						left_ok  = left_cnt_d >= grp_thr;
						both_ok  = right_ok && left_ok;

						if ((stop_cnt_d >= stop_thr) && speed_ge(cur_speed_q, speed_thr_q[15:0])
							&& !stopping_q) begin
							// emergency stop
							res_d.gear_valid   = 1'b1;
							res_d.gear_level   = lzsgm_pkg::GEAR_STOP;
							res_d.motion_valid = 1'b1;
							res_d.motion_kind  = lzsgm_pkg::MOTION_STOP;
							res_d.light_valid  = 1'b1;
							res_d.light_alert  = 1'b1;
							stopping_d = 1'b1;
							mode_d     = lzsgm_pkg::MM_STOP;
							decided_d  = 1'b1;
						end else if (both_ok && speed_ge(cur_speed_q, speed_thr_q[31:16])) begin
							// slow-down, second confirmation acts
							down_conf_d = down_conf_q + 2'd1;
							if (down_conf_d == 2'd2) begin
								since_slow_d = 32'd0;
								if (mode_q != lzsgm_pkg::MM_GEAR1) begin
									res_d.gear_valid = 1'b1;
									res_d.gear_level = lzsgm_pkg::GEAR_SLOW;
									mode_d    = lzsgm_pkg::MM_GEAR1;
									up_conf_d = 2'd0;
								end
								down_conf_d = 2'd0;
							end
							decided_d = 1'b1;
						end else if ((stop_cnt_d <= lzsgm_pkg::FREE_STOP_LIMIT) && !both_ok
							&& near_end && speed_ge(cur_speed_q, speed_thr_q[47:32])) begin
							// clear zone near window end
							up_conf_d = up_conf_q + 2'd1;
							if (up_conf_d == 2'd2) begin
								if (mode_q != lzsgm_pkg::MM_FREE) begin
									if (since_slow_q >= up_gear_ticks_q) begin
										res_d.gear_valid = 1'b1;
										res_d.gear_level = lzsgm_pkg::GEAR_FREE;
										mode_d = lzsgm_pkg::MM_FREE;
									end
									down_conf_d = 2'd0;
								end
								up_conf_d = 2'd0;
							end
							decided_d = 1'b1;
						end
					end
					if (last_s1) begin
						stop_cnt_d  = '0;
						right_cnt_d = '0;
						left_cnt_d  = '0;
						decided_d   = 1'b0;
					end
				end
			end
			lzsgm_pkg::ACT_SPEED: begin
				if (enabled) begin
					cur_speed_d = speed_s1;
					if ((speed_s1 <= lzsgm_pkg::SLOW_SPEED_MM_S) && stopping_q) begin
						if (mode_flags_q[1]) begin
							mode_d             = lzsgm_pkg::MM_RECOIL;
							res_d.motion_valid = 1'b1;
							res_d.motion_kind  = lzsgm_pkg::MOTION_RECOIL;
						end
						stopping_d        = 1'b0;
						res_d.light_valid = 1'b1;
						res_d.light_alert = 1'b0;
					end
				end
			end
			lzsgm_pkg::ACT_TICK: begin
				if (since_slow_q != 32'hFFFF_FFFF) begin
					since_slow_d = since_slow_q + 32'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_cnt_q   <= '0;
			right_cnt_q  <= '0;
			left_cnt_q   <= '0;
			decided_q    <= 1'b0;
			down_conf_q  <= 2'd0;
			up_conf_q    <= 2'd0;
			mode_q       <= lzsgm_pkg::MM_NONE;
			stopping_q   <= 1'b0;
			cur_speed_q  <= 16'sd0;
			since_slow_q <= 32'hFFFF_FFFF;
		end else if (advance) begin
			stop_cnt_q   <= stop_cnt_d;
			right_cnt_q  <= right_cnt_d;
			left_cnt_q   <= left_cnt_d;
			decided_q    <= decided_d;
			down_conf_q  <= down_conf_d;
			up_conf_q    <= up_conf_d;
			mode_q       <= mode_d;
			stopping_q   <= stopping_d;
			cur_speed_q  <= cur_speed_d;
			since_slow_q <= since_slow_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = lzsgm_pkg::M_TDATA_W'(res_q);

endmodule

/* rtl/core/lzsgm_checker.sv */
// Port-level checker for the lidar zone stop / gear monitor, with its bind.
// Depends on lidar_zone_stop_gear_monitor_macros.svh and lzsgm_pkg.
`include "lidar_zone_stop_gear_monitor_macros.svh"

module lzsgm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [lzsgm_pkg::S_TDATA_W-1:0]   s_tdata,
	input logic                              s_tlast,
	input logic [1:0]                        s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [lzsgm_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic                              cfg_we,
	input logic [lzsgm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [lzsgm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic stalled;
	logic stop_alert;
	logic recoil;

	assign stalled    = m_tvalid && !m_tready;
	assign stop_alert = m_tvalid && m_tdata[5] && m_tdata[6];
	assign recoil     = m_tvalid && m_tdata[3] && m_tdata[4];

	// a held result stays offered and unchanged
	`LZSGM_ASSERT_NEXT(a_hold_valid, stalled, m_tvalid)
	`LZSGM_ASSERT_NEXT(a_hold_data, stalled, $stable(m_tdata))
	// no gear level without a gear announcement
	`LZSGM_ASSERT_NOW(a_gear_quiet, m_tvalid && !m_tdata[0], m_tdata[2:1] == lzsgm_pkg::GEAR_FREE)
	// alert light on only together with stop command and emergency gear
	`LZSGM_ASSERT_NOW(a_alert_stop, stop_alert,
		m_tdata[0] && (m_tdata[2:1] == lzsgm_pkg::GEAR_STOP) && m_tdata[3] && !m_tdata[4])
	// recoil always comes with the light going back to normal
	`LZSGM_ASSERT_NOW(a_recoil_light, recoil, m_tdata[5] && !m_tdata[6] && !m_tdata[0])

endmodule

bind lidar_zone_stop_gear_monitor lzsgm_checker u_lzsgm_checker (.*);
